>>> rtl/core/lsag_pkg.sv
package lsag_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 72;

  typedef logic [WordW-1:0]  word_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [1:0]        op_t;

  localparam op_t OP_WORD  = 2'd0;
  localparam op_t OP_HALF  = 2'd1;
  localparam op_t OP_BLOCK = 2'd2;
  localparam op_t OP_NONE  = 2'd3;

  localparam logic [1:0] SHIFT_LSL = 2'd0;
  localparam logic [1:0] SHIFT_LSR = 2'd1;
  localparam logic [1:0] SHIFT_ASR = 2'd2;
  localparam logic [1:0] SHIFT_ROR = 2'd3;

  typedef struct packed {
    op_t    op;
    logic   pre;
    logic   up;
    logic   wb;
    word_t  base;
    word_t  off;
    count_t count;
  } s1_t;

  typedef struct packed {
    op_t    op;
    logic   pre;
    logic   up;
    logic   wb;
    word_t  base;
    word_t  moved;
    word_t  blk_up;
    word_t  blk_dn;
    word_t  base_p4;
    count_t count;
  } s2_t;

  typedef struct packed {
    logic   user;
    count_t count;
    word_t  new_value;
    logic   writeback;
    word_t  address;
  } res_t;

endpackage

>>> rtl/core/load_store_address_generator.sv
// Load/store address generator. Each input beat carries one load/store
// instruction word with its base and offset register values and the carry
// flag; each output beat carries the first transfer address, the base
// writeback flag and value, the register count (population count of the
// list for block transfers, 1 for single transfers) and the user-access flag
// of the post-indexed word/byte T forms. One beat is accepted per cycle
// while the output is not stalled, and each result passes through offset
// decode and shift, then the base adders, then the final selection into the
// output register. A stall on the output holds the whole pipeline.
module load_store_address_generator
  import lsag_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  // [31:0] instruction, [63:32] base_value, [95:64] index_value,
  // [96] carry_in, [103:97] zero
  input  logic [InDataW-1:0]  in_tdata,
  // [1:0] operation
  input  logic [1:0]          in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  // [31:0] address, [32] base_writeback, [64:33] base_new_value,
  // [69:65] register_count, [70] user_access, [71] zero
  output logic [OutDataW-1:0] out_tdata
);

  logic  adv;
  logic  v1_r, v2_r, v3_r;
  logic  v1_nxt, v2_nxt, v3_nxt;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  res_t  s3_r, s3_nxt;

  word_t       instr, base_in, rm;
  logic        carry;
  logic [4:0]  amt;
  word_t       shifted;
  word_t       off;
  count_t      pop;

  assign adv       = !v3_r || out_tready;
  assign in_tready = adv;

  assign instr   = in_tdata[31:0];
  assign base_in = in_tdata[63:32];
  assign rm      = in_tdata[95:64];
  assign carry   = in_tdata[96];
  assign amt     = instr[11:7];

  // stage 1: offset decode, shifter, list count
  always_comb begin
    logic [2*WordW-1:0] rot;
    rot = {rm, rm} >> amt;
    unique case (instr[6:5])
      SHIFT_LSL: shifted = rm << amt;
      SHIFT_LSR: shifted = (amt == 5'd0) ? '0 : (rm >> amt);
      SHIFT_ASR: shifted = (amt == 5'd0) ? {WordW{rm[WordW-1]}}
                                         : word_t'($signed(rm) >>> amt);
      SHIFT_ROR: shifted = (amt == 5'd0) ? {carry, rm[WordW-1:1]}
                                         : rot[WordW-1:0];
      default:   shifted = rm;
    endcase
  end

  always_comb begin
    pop = '0;
    for (int i = 0; i < 16; i++) begin
      pop = pop + count_t'(instr[i]);
    end
  end

  always_comb begin
    off = rm;
    if (in_tuser == OP_HALF) begin
      if (instr[22]) begin
        off = {24'd0, instr[11:8], instr[3:0]};
      end
    end else if (!instr[25]) begin
      off = {20'd0, instr[11:0]};
    end else if (instr[11:4] != 8'd0) begin
      off = shifted;
    end
  end

  always_comb begin
    s1_nxt.op   = in_tuser;
    s1_nxt.pre  = instr[24];
    s1_nxt.up   = instr[23];
    s1_nxt.wb   = instr[21];
    s1_nxt.base = base_in;
    s1_nxt.off  = off;
    unique case (in_tuser)
      OP_WORD, OP_HALF: s1_nxt.count = count_t'(1);
      OP_BLOCK:         s1_nxt.count = pop;
      default:          s1_nxt.count = '0;
    endcase
  end

  // stage 2: base adders
  always_comb begin
    word_t span;
    span = {{(WordW-CountW-2){1'b0}}, s1_r.count, 2'b00};
    s2_nxt.op      = s1_r.op;
    s2_nxt.pre     = s1_r.pre;
    s2_nxt.up      = s1_r.up;
    s2_nxt.wb      = s1_r.wb;
    s2_nxt.base    = s1_r.base;
    s2_nxt.count   = s1_r.count;
    s2_nxt.moved   = s1_r.up ? s1_r.base + s1_r.off : s1_r.base - s1_r.off;
    s2_nxt.blk_up  = s1_r.base + span;
    s2_nxt.blk_dn  = s1_r.base - span;
    s2_nxt.base_p4 = s1_r.base + word_t'(4);
  end

  // stage 3: result select
  always_comb begin
    s3_nxt.address   = s2_r.base;
    s3_nxt.writeback = 1'b0;
    s3_nxt.new_value = s2_r.base;
    s3_nxt.count     = s2_r.count;
    s3_nxt.user      = 1'b0;
    unique case (s2_r.op)
      OP_WORD, OP_HALF: begin
        s3_nxt.new_value = s2_r.moved;
        if (s2_r.pre) begin
          s3_nxt.address   = s2_r.moved;
          s3_nxt.writeback = s2_r.wb;
        end else begin
          s3_nxt.writeback = 1'b1;
          s3_nxt.user      = (s2_r.op == OP_WORD) && s2_r.wb;
        end
      end
      OP_BLOCK: begin
        s3_nxt.writeback = s2_r.wb;
        if (s2_r.up) begin
          s3_nxt.address   = s2_r.pre ? s2_r.base_p4 : s2_r.base;
          s3_nxt.new_value = s2_r.blk_up;
        end else begin
          s3_nxt.address   = s2_r.pre ? s2_r.blk_dn : s2_r.blk_dn + word_t'(4);
          s3_nxt.new_value = s2_r.blk_dn;
        end
      end
      default: begin
      end
    endcase
  end

  assign v1_nxt = adv ? in_tvalid : v1_r;
  assign v2_nxt = adv ? v1_r : v2_r;
  assign v3_nxt = adv ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = {1'b0, s3_r};

  a_user_implies_wb: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.user |-> s3_r.writeback)
    else $error("user access without base writeback");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> s3_r.count <= count_t'(16))
    else $error("register count out of range");

  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && adv |=> v3_r)
    else $error("beat lost between stage 2 and output");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (v1_r == $past(v1_r)) && (v2_r == $past(v2_r)))
    else $error("pipeline moved during output stall");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import lsag_pkg::*;

  localparam int ItemCount    = 1750;
  localparam int QuietTail    = 200;
  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 10;

  // instruction bit positions
  localparam int BitI = 25;
  localparam int BitP = 24;
  localparam int BitU = 23;
  localparam int BitB = 22;
  localparam int BitW = 21;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  // [31:0] instruction, [63:32] base_value, [95:64] index_value,
  // [96] carry_in, [103:97] zero
  logic [InDataW-1:0]  in_tdata;
  // [1:0] operation
  logic [1:0]          in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  // [31:0] address, [32] base_writeback, [64:33] base_new_value,
  // [69:65] register_count, [70] user_access, [71] zero
  logic [OutDataW-1:0] out_tdata;

  res_t pending_results[$];
  res_t got_res;
  res_t want_res;
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_left = 0;
  bit   idle_on = 1'b1;

  load_store_address_generator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic res_t predict_access(op_t op, word_t instr, word_t base, word_t rm,
                                          logic carry);
    res_t        r;
    word_t       off;
    word_t       moved;
    word_t       span;
    logic [4:0]  amt;
    int unsigned cnt;
    r.address   = base;
    r.writeback = 1'b0;
    r.new_value = base;
    r.count     = '0;
    r.user      = 1'b0;
    amt = instr[11:7];
    off = rm;
    if (op == OP_WORD || op == OP_HALF) begin
      if (op == OP_WORD) begin
        if (!instr[BitI]) begin
          off = {20'd0, instr[11:0]};
        end else if (instr[11:4] == 8'd0) begin
          off = rm;
        end else begin
          case (instr[6:5])
            SHIFT_LSL: off = rm << amt;
            SHIFT_LSR: off = (amt == 5'd0) ? '0 : rm >> amt;
            SHIFT_ASR: off = (amt == 5'd0) ? {32{rm[31]}} : word_t'($signed(rm) >>> amt);
            SHIFT_ROR: begin
              if (amt == 5'd0) off = {carry, rm[31:1]};
              else off = (rm >> amt) | (rm << (6'd32 - {1'b0, amt}));
            end
          endcase
        end
      end else if (instr[BitB]) begin
        off = {24'd0, instr[11:8], instr[3:0]};
      end else begin
        off = rm;
      end
      moved   = instr[BitU] ? base + off : base - off;
      r.count = count_t'(1);
      r.new_value = moved;
      if (instr[BitP]) begin
        r.address   = moved;
        r.writeback = instr[BitW];
      end else begin
        r.address   = base;
        r.writeback = 1'b1;
        r.user      = (op == OP_WORD) && instr[BitW];
      end
    end else if (op == OP_BLOCK) begin
      cnt     = $countones(instr[15:0]);
      span    = word_t'(cnt) << 2;
      r.count = count_t'(cnt);
      if (instr[BitU]) begin
        r.address   = instr[BitP] ? base + 32'd4 : base;
        r.new_value = base + span;
      end else begin
        r.address   = instr[BitP] ? base - span : base - span + 32'd4;
        r.new_value = base - span;
      end
      r.writeback = instr[BitW];
    end
    return r;
  endfunction

  function automatic word_t form_word(bit p, bit u, bit b, bit w, bit i, logic [15:0] low);
    word_t instr;
    instr = $urandom;
    instr[BitI] = i;
    instr[BitP] = p;
    instr[BitU] = u;
    instr[BitB] = b;
    instr[BitW] = w;
    instr[15:0] = low;
    return instr;
  endfunction

  function automatic logic [15:0] shift_field(logic [4:0] amt, logic [1:0] kind, bit b4);
    return {4'h5, amt, kind, b4, 4'h3};
  endfunction

  function automatic word_t pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_beat(op_t op, word_t instr, word_t base, word_t rm, logic carry);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, carry, rm, base, instr};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_access(op, instr, base, rm, carry));
  endtask

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic test_word_offsets();
    send_beat(OP_WORD, form_word(1, 1, 0, 0, 0, 16'h1FFF), 32'h0000_1000, $urandom, 1'b0);
    send_beat(OP_WORD, form_word(1, 0, 1, 1, 0, 16'h2000), 32'hFFFF_FFFF, $urandom, 1'b1);
    send_beat(OP_WORD, form_word(0, 1, 0, 1, 0, 16'h3ABC), 32'hFFFF_F000, $urandom, 1'b0);
    send_beat(OP_WORD, form_word(0, 0, 0, 0, 0, 16'h4FFF), 32'h0000_0000, $urandom, 1'b1);
    send_beat(OP_WORD, form_word(1, 1, 0, 1, 1, 16'h5003), 32'h0000_0010, 32'hFFFF_FFFF, 1'b0);
  endtask

  task automatic test_word_shifts();
    send_beat(OP_WORD, form_word(1, 1, 0, 0, 1, shift_field(5'd31, SHIFT_LSL, 0)),
              32'h0000_0100, 32'h0000_0003, 1'b0);
    send_beat(OP_WORD, form_word(1, 0, 0, 1, 1, shift_field(5'd0, SHIFT_LSR, 0)),
              32'h1234_5678, 32'hFFFF_FFFF, 1'b1);
    send_beat(OP_WORD, form_word(1, 1, 0, 0, 1, shift_field(5'd31, SHIFT_LSR, 0)),
              32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_WORD, form_word(1, 1, 0, 0, 1, shift_field(5'd0, SHIFT_ASR, 0)),
              32'h0000_0000, 32'h8000_0001, 1'b0);
    send_beat(OP_WORD, form_word(0, 0, 1, 0, 1, shift_field(5'd7, SHIFT_ASR, 0)),
              32'h0000_4000, 32'hF000_0F00, 1'b1);
    send_beat(OP_WORD, form_word(1, 1, 0, 1, 1, shift_field(5'd0, SHIFT_ROR, 0)),
              32'h0000_0000, 32'h0000_0003, 1'b1);
    send_beat(OP_WORD, form_word(0, 1, 0, 1, 1, shift_field(5'd0, SHIFT_ROR, 0)),
              32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    // bit 4 set: still an immediate shift amount
    send_beat(OP_WORD, form_word(1, 0, 0, 0, 1, shift_field(5'd16, SHIFT_ROR, 1)),
              32'h0000_0000, 32'h1234_ABCD, 1'b0);
  endtask

  task automatic test_halfword();
    send_beat(OP_HALF, form_word(1, 1, 1, 1, 0, 16'h6F0F), 32'hFFFF_FF80, $urandom, 1'b0);
    send_beat(OP_HALF, form_word(0, 0, 0, 1, 0, 16'h70B4), 32'h0000_0004, 32'h0000_0008, 1'b1);
    send_beat(OP_HALF, form_word(0, 1, 1, 0, 1, 16'h8A05), 32'h8000_0000, $urandom, 1'b0);
  endtask

  task automatic test_block_modes();
    send_beat(OP_BLOCK, form_word(0, 1, 0, 1, 0, 16'h8001), 32'h0000_2000, $urandom, 1'b0);
    send_beat(OP_BLOCK, form_word(1, 1, 0, 1, 1, 16'h00F0), 32'hFFFF_FFF8, $urandom, 1'b1);
    send_beat(OP_BLOCK, form_word(0, 0, 0, 0, 0, 16'h0F0F), 32'h0000_0008, $urandom, 1'b0);
    send_beat(OP_BLOCK, form_word(1, 0, 0, 1, 1, 16'hAAAA), 32'h0000_0000, $urandom, 1'b1);
    // empty list
    send_beat(OP_BLOCK, form_word(1, 0, 0, 1, 0, 16'h0000), 32'h0000_0100, $urandom, 1'b0);
    // full list, S bit set
    send_beat(OP_BLOCK, form_word(1, 1, 1, 1, 0, 16'hFFFF), 32'hFFFF_FFC0, $urandom, 1'b1);
  endtask

  task automatic test_unused_op();
    send_beat(OP_NONE, $urandom, 32'hDEAD_BEEF, $urandom, 1'b1);
  endtask

  task automatic test_random_traffic();
    op_t   op;
    word_t instr;
    int    sel;
    for (int n = 0; n < ItemCount; n++) begin
      if (n == ItemCount - QuietTail) idle_on = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 4) op = OP_WORD;
      else if (sel < 6) op = OP_HALF;
      else if (sel < 9) op = OP_BLOCK;
      else op = OP_NONE;
      instr = $urandom;
      if (op == OP_WORD) begin
        if (instr[BitI] && $urandom_range(0, 3) == 0) instr[11:4] = 8'd0;
        if ($urandom_range(0, 3) == 0) instr[11:7] = 5'd0;
      end else if (op == OP_BLOCK) begin
        case ($urandom_range(0, 7))
          0: instr[15:0] = 16'h0000;
          1: instr[15:0] = 16'hFFFF;
          2: instr[15:0] = 16'h0001 << $urandom_range(0, 15);
          default: ;
        endcase
      end
      send_beat(op, instr, pick_value(), pick_value(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res = res_t'(out_tdata[$bits(res_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat, expected none actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want_res = pending_results.pop_front();
        report_field("address", want_res.address, got_res.address);
        report_field("base_writeback", 32'(want_res.writeback), 32'(got_res.writeback));
        report_field("base_new_value", want_res.new_value, got_res.new_value);
        report_field("register_count", 32'(want_res.count), 32'(got_res.count));
        report_field("user_access", 32'(want_res.user), 32'(got_res.user));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_WORD;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_word_offsets();
    test_word_shifts();
    test_halfword();
    test_block_modes();
    test_unused_op();
    test_random_traffic();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/lsag_pkg.sv
rtl/core/load_store_address_generator.sv
sim/testbench.sv
